[rtl/imt_pkg.sv]
// ----------------------------------------------------------------------------
// imt_pkg: shared types for the IP membership table
// Request codes, sequencer states and the result handoff between the
// sequencer and the output stage.
// ----------------------------------------------------------------------------
package imt_pkg;

  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_CLEAR  = 2'd2,
    REQ_LOOKUP = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_DONE
  } seq_state_t;

  // Result handoff from the sequencer to the output register.
  typedef struct packed {
    logic valid;
    logic ok;
  } imt_res_t;

endpackage

[rtl/imt_ram.sv]
// ----------------------------------------------------------------------------
// imt_ram: generic single-write, single-read RAM
// One write port and one read port per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module imt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/imt_seq.sv]
// ----------------------------------------------------------------------------
// imt_seq: request sequencer and address comparator
// Walks the stored entries through the RAM read port with one shared
// comparator, appends on a missed add and compacts the list after a remove.
// ----------------------------------------------------------------------------
module imt_seq #(
  parameter int DEPTH = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  imt_pkg::req_type_t                  req_type,
  input  logic [31:0]                         address,
  output imt_pkg::imt_res_t                   res,
  input  logic                                res_ready,
  output logic [$clog2(DEPTH+1)-1:0]          count,
  output logic                                ram_we,
  output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] ram_waddr,
  output logic [31:0]                         ram_wdata,
  output logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] ram_raddr,
  input  logic [31:0]                         ram_rdata
);
  import imt_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  seq_state_t state, state_next;
  req_type_t  kind, kind_next;
  logic [31:0]   addr_r, addr_next;
  logic [CW-1:0] count_next;
  logic [CW-1:0] ridx, ridx_next;
  logic [CW-1:0] cidx, cidx_next;
  logic [CW-1:0] widx, widx_next;
  logic          pend, pend_next;
  logic          res_ok, res_ok_next;
  logic          hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    kind   <= kind_next;
    addr_r <= addr_next;
    ridx   <= ridx_next;
    cidx   <= cidx_next;
    widx   <= widx_next;
    res_ok <= res_ok_next;
  end

  // The one comparator: read data of the entry fetched last cycle.
  assign hit = pend && (ram_rdata == addr_r);

  always_comb begin
    state_next  = state;
    kind_next   = kind;
    addr_next   = addr_r;
    count_next  = count;
    ridx_next   = ridx;
    cidx_next   = cidx;
    widx_next   = widx;
    pend_next   = pend;
    res_ok_next = res_ok;
    in_ready    = 1'b0;
    res.valid   = 1'b0;
    res.ok      = res_ok;
    ram_we      = 1'b0;
    ram_waddr   = widx[IW-1:0];
    ram_wdata   = ram_rdata;
    ram_raddr   = ridx[IW-1:0];

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          kind_next = req_type;
          addr_next = address;
          ridx_next = '0;
          pend_next = 1'b0;
          state_next = ST_SCAN;
          if (req_type == REQ_CLEAR) begin
            count_next  = '0;
            res_ok_next = 1'b1;
            state_next  = ST_DONE;
          end else if (req_type == REQ_ADD && (address == 32'd0 || count == DEPTH_C)) begin
            res_ok_next = 1'b0;
            state_next  = ST_DONE;
          end
        end
      end

      ST_SCAN: begin
        if (hit) begin
          pend_next = 1'b0;
          if (kind == REQ_REMOVE) begin
            ridx_next  = cidx + ONE_C;
            widx_next  = cidx;
            state_next = ST_SHIFT;
          end else begin
            res_ok_next = 1'b1;
            state_next  = ST_DONE;
          end
        end else if (ridx < count) begin
          pend_next = 1'b1;
          cidx_next = ridx;
          ridx_next = ridx + ONE_C;
        end else begin
          // Every stored entry missed.
          pend_next = 1'b0;
          if (kind == REQ_ADD) begin
            ram_we      = 1'b1;
            ram_waddr   = count[IW-1:0];
            ram_wdata   = addr_r;
            count_next  = count + ONE_C;
            res_ok_next = 1'b1;
          end else begin
            res_ok_next = 1'b0;
          end
          state_next = ST_DONE;
        end
      end

      ST_SHIFT: begin
        // Read one slot ahead and write the fetched entry one slot down.
        if (pend) begin
          ram_we    = 1'b1;
          widx_next = widx + ONE_C;
        end
        if (ridx < count) begin
          pend_next = 1'b1;
          ridx_next = ridx + ONE_C;
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            count_next  = count - ONE_C;
            res_ok_next = 1'b1;
            state_next  = ST_DONE;
          end
        end
      end

      ST_DONE: begin
        res.valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/ip_membership_table.sv]
// ----------------------------------------------------------------------------
// ip_membership_table: packed set of nonzero IPv4 addresses
// Add, remove, clear and lookup requests against up to DEPTH stored
// addresses, one result beat per request beat.
// ----------------------------------------------------------------------------
// Each request beat yields exactly one result beat carrying ok and the entry
// count after the request. The entries sit in a single-port-read RAM and are
// compared one per cycle by a shared comparator. A lookup, a remove or an add
// scans the stored entries in order and stops at the first match, or reads
// every stored entry when none matches. A clear or a rejected add skips the
// scan. A remove that matches an entry then compacts the list, moving each
// entry after the removed one down one slot. The input is not ready while a
// request is in work; a finished result waits in the output register and the
// next request beat is taken meanwhile. No clearing pass is needed after
// reset.
module ip_membership_table #(
  parameter int DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // req_type [1:0], address [33:2], zero [39:34]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // ok [0], entry_count [4:1], zero [7:5]
);
  import imt_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  imt_res_t          res;
  logic              res_ready;
  logic [CW-1:0]     count;
  logic [CW+3:0]     count_ext;
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [31:0]       ram_wdata;
  logic [IW-1:0]     ram_raddr;
  logic [31:0]       ram_rdata;
  logic              out_ok;
  logic [3:0]        out_count;

  imt_seq #(.DEPTH(DEPTH)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .req_type  (req_type_t'(s_tdata[1:0])),
    .address   (s_tdata[33:2]),
    .res       (res),
    .res_ready (res_ready),
    .count     (count),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  imt_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The count reports modulo 16.
  assign count_ext = {4'b0000, count};
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res.valid) begin
      out_ok    <= res.ok;
      out_count <= count_ext[3:0];
    end
  end

  assign m_tdata = {3'b000, out_count, out_ok};

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while another is in work");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("entry count exceeds table depth");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tdata[1:0] == REQ_CLEAR) |=> (count == '0))
    else $error("clear left entries in the table");

  a_result_after_request: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> !s_tready)
    else $error("result pending while input is ready");

endmodule

[dv/tb_ip_membership_table.sv]
// ----------------------------------------------------------------------------
// tb_ip_membership_table: self-checking bench for the IP membership table
// Drives add, remove, clear and lookup requests into the stream input. A
// behavioral copy of the table predicts ok and the entry count for every
// accepted request, and each result beat is checked against the oldest
// prediction. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_ip_membership_table;
  import imt_pkg::*;

  localparam int TABLE_DEPTH = 8;
  localparam int QUIET_LIMIT = 4000;
  localparam int RANDOM_SEGMENTS = 10;
  localparam int SEGMENT_ITEMS = 60;
  localparam int POOL_SIZE = 16;

  typedef struct packed {
    logic       ok;
    logic [3:0] count;
  } reply_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // req_type [1:0], address [33:2], zero [39:34]
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // ok [0], entry_count [4:1], zero [7:5]

  // Behavioral copy of the table.
  logic [31:0] shadow_addr [TABLE_DEPTH];
  int          shadow_used;

  reply_t      expected_replies [$];
  int          fail_count;
  int          quiet_cycles;
  bit          idle_on;
  logic [31:0] addr_pool [POOL_SIZE];

  ip_membership_table #(
    .DEPTH(TABLE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic reply_t table_predict(req_type_t kind, logic [31:0] addr);
    int slot;
    reply_t r;
    slot = -1;
    for (int i = 0; i < shadow_used; i++) begin
      if (slot < 0 && shadow_addr[i] == addr) slot = i;
    end
    r.ok = 1'b0;
    case (kind)
      REQ_ADD: begin
        // A full table rejects even an address it already holds.
        if (addr != 32'd0 && shadow_used < TABLE_DEPTH) begin
          if (slot < 0) begin
            shadow_addr[shadow_used] = addr;
            shadow_used++;
          end
          r.ok = 1'b1;
        end
      end
      REQ_REMOVE: begin
        if (slot >= 0) begin
          for (int j = slot; j < shadow_used - 1; j++) shadow_addr[j] = shadow_addr[j + 1];
          shadow_used--;
          r.ok = 1'b1;
        end
      end
      REQ_CLEAR: begin
        shadow_used = 0;
        r.ok = 1'b1;
      end
      default: begin
        r.ok = (shadow_used != 0 && slot >= 0);
      end
    endcase
    r.count = shadow_used[3:0];
    return r;
  endfunction

  task automatic note_failure(string what);
    fail_count++;
    if (fail_count <= 10) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  // Presents one request beat and returns once it has been accepted. The
  // valid stays high afterwards so that back-to-back beats need no toggle.
  task automatic send_req(req_type_t kind, logic [31:0] addr);
    int gap;
    gap = idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'd0, addr, kind};
    do @(posedge clk); while (!s_tready);
    expected_replies.push_back(table_predict(kind, addr));
  endtask

  task automatic test_empty_table();
    send_req(REQ_LOOKUP, 32'd0);
    send_req(REQ_LOOKUP, 32'hFFFF_FFFF);
    send_req(REQ_REMOVE, 32'h0A00_0001);
    send_req(REQ_ADD, 32'd0);
    send_req(REQ_CLEAR, 32'hDEAD_BEEF);
  endtask

  task automatic test_fill_and_overflow();
    send_req(REQ_ADD, 32'hFFFF_FFFF);
    send_req(REQ_ADD, 32'h0000_0001);
    send_req(REQ_ADD, 32'h8000_0000);
    send_req(REQ_ADD, 32'h7FFF_FFFF);
    send_req(REQ_ADD, 32'hC0A8_0001);
    send_req(REQ_ADD, 32'h0A00_0001);
    send_req(REQ_ADD, 32'h0000_0001);
    send_req(REQ_ADD, 32'h0A00_0002);
    send_req(REQ_ADD, 32'hAC10_0001);
    send_req(REQ_ADD, 32'h1234_5678);
    send_req(REQ_ADD, 32'h0000_0001);
    send_req(REQ_LOOKUP, 32'hAC10_0001);
  endtask

  task automatic test_remove_compaction();
    send_req(REQ_REMOVE, 32'h0000_0001);
    send_req(REQ_REMOVE, 32'hFFFF_FFFF);
    send_req(REQ_REMOVE, 32'hAC10_0001);
    send_req(REQ_REMOVE, 32'd0);
    send_req(REQ_LOOKUP, 32'h0A00_0002);
    send_req(REQ_CLEAR, 32'd0);
    send_req(REQ_LOOKUP, 32'h0A00_0002);
  endtask

  function automatic req_type_t pick_kind(int add_w, int rem_w, int look_w);
    int draw;
    draw = $urandom_range(0, 99);
    if (draw < add_w) return REQ_ADD;
    if (draw < add_w + rem_w) return REQ_REMOVE;
    if (draw < add_w + rem_w + look_w) return REQ_LOOKUP;
    return REQ_CLEAR;
  endfunction

  function automatic logic [31:0] pick_addr();
    int draw;
    draw = $urandom_range(0, 99);
    if (draw < 5) return 32'd0;
    if (draw < 15) return $urandom();
    return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  // Addresses come mostly from a small pool so that hits, duplicates and a
  // full table are common; segments lean toward growing or shrinking.
  task automatic test_random_traffic();
    bit grow;
    for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = $urandom();
    addr_pool[0] = 32'hFFFF_FFFF;
    addr_pool[1] = 32'h0000_0001;
    for (int seg = 0; seg < RANDOM_SEGMENTS; seg++) begin
      grow    = $urandom_range(0, 1);
      idle_on = (seg % 3 != 0);
      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        if (grow) send_req(pick_kind(55, 15, 27), pick_addr());
        else send_req(pick_kind(25, 40, 30), pick_addr());
      end
    end
    idle_on = 1'b1;
  endtask

  // Result side: a random stall before each beat.
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      stall = idle_on ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.ok    = m_tdata[0];
      got.count = m_tdata[4:1];
      if (expected_replies.size() == 0) begin
        note_failure($sformatf("result beat ok=%0b count=%0d with nothing pending",
                               got.ok, got.count));
      end else begin
        want = expected_replies.pop_front();
        if (got.ok !== want.ok)
          note_failure($sformatf("ok expected %0b got %0b", want.ok, got.ok));
        if (got.count !== want.count)
          note_failure($sformatf("entry_count expected %0d got %0d", want.count, got.count));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    fail_count  = 0;
    quiet_cycles = 0;
    shadow_used = 0;
    idle_on     = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_table();
    test_fill_and_overflow();
    test_remove_compaction();
    test_random_traffic();
    s_tvalid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0 && expected_replies.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[ip_membership_table.f]
rtl/imt_pkg.sv
rtl/imt_ram.sv
rtl/imt_seq.sv
rtl/ip_membership_table.sv
dv/tb_ip_membership_table.sv
